[rtl/boa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap offset allocator package
// Shared command codes, widths and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package boa_pkg;

    localparam int OFS_W   = 10;
    localparam int SIZE_W  = 11;
    localparam int CMD_W   = 3;
    localparam int MAP_W   = 32;
    localparam int BIT_W   = 5;
    localparam int OFS_SPACE = 1024;

    typedef enum logic [CMD_W-1:0] {
        CMD_QUERY   = 3'd0,
        CMD_ALLOC   = 3'd1,
        CMD_FIRST   = 3'd2,
        CMD_REVERSE = 3'd3,
        CMD_LAST    = 3'd4,
        CMD_FREE    = 3'd5
    } cmd_t;

    localparam logic CFG_START = 1'b0;
    localparam logic CFG_SIZE  = 1'b1;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } ctl_t;

    typedef struct packed {
        logic is_search;
        logic span_ok;
        logic hit;
        logic last;
    } sts_t;

endpackage

`default_nettype wire

[rtl/boa_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap offset allocator controller
// Sequences one command: load, then one map word per cycle until it ends.
// ----------------------------------------------------------------------------
module boa_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    output logic               done,
    input  boa_pkg::sts_t      sts,
    output boa_pkg::ctl_t      ctl
);
    import boa_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;
    logic   finish;

    assign finish = !sts.is_search || !sts.span_ok || sts.hit || sts.last;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctl.step   = 1'b1;
                ctl.finish = finish;
                if (finish)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;

endmodule

`default_nettype wire

[rtl/boa_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap offset allocator datapath
// Holds the used-bit map as 32-bit words, the search bounds and the result.
// ----------------------------------------------------------------------------
module boa_datapath
#(
    parameter int POOL_BITS = 1024
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  boa_pkg::ctl_t                      ctl,
    output boa_pkg::sts_t                      sts,
    input  wire logic [boa_pkg::CMD_W-1:0]     command,
    input  wire logic [boa_pkg::OFS_W-1:0]     target,
    input  wire logic [boa_pkg::OFS_W-1:0]     range_start,
    input  wire logic [boa_pkg::SIZE_W-1:0]    range_size,
    output logic                               ok,
    output logic [boa_pkg::OFS_W-1:0]          granted
);
    import boa_pkg::*;

    localparam int EFF_BITS = (POOL_BITS < OFS_SPACE) ? POOL_BITS : OFS_SPACE;
    localparam int NWORDS   = (EFF_BITS + MAP_W - 1) / MAP_W;
    localparam int WI       = (NWORDS > 1) ? $clog2(NWORDS) : 1;

    function automatic logic [BIT_W-1:0] lowest_set(input logic [MAP_W-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = MAP_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [BIT_W-1:0] highest_set(input logic [MAP_W-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < MAP_W; i++)
        begin
            if (v[i])
            begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

    logic [MAP_W-1:0]  map_reg [NWORDS];

    cmd_t              cmd_reg;
    logic [OFS_W-1:0]  target_reg;
    logic [OFS_W-1:0]  lo_reg;
    logic [OFS_W-1:0]  hi_reg;
    logic [WI-1:0]     word_reg;
    logic              span_ok_reg;
    logic              ok_reg;
    logic [OFS_W-1:0]  granted_reg;

    cmd_t              cmd_in;
    logic [SIZE_W:0]   top_sum;
    logic [SIZE_W-1:0] top;
    logic [OFS_W-1:0]  top_m1;
    logic              tgt_in;
    logic              range_ne;
    logic [OFS_W-1:0]  lo_next;
    logic [OFS_W-1:0]  hi_next;
    logic              span_ok_next;
    logic              down_next;

    logic              is_search;
    logic              is_down;
    logic [WI-1:0]     lo_word;
    logic [WI-1:0]     hi_word;
    logic [MAP_W-1:0]  cur_word;
    logic [MAP_W-1:0]  lo_mask;
    logic [MAP_W-1:0]  hi_mask;
    logic [MAP_W-1:0]  cand;
    logic [BIT_W-1:0]  hit_bit;
    logic              tgt_used;
    logic              single_ok;
    logic [MAP_W-1:0]  new_word;

    assign cmd_in   = cmd_t'(command);
    assign top_sum  = {2'b00, range_start} + {1'b0, range_size};
    assign top      = (top_sum > (SIZE_W + 1)'(EFF_BITS)) ? SIZE_W'(EFF_BITS)
                                                          : top_sum[SIZE_W-1:0];
    assign top_m1   = OFS_W'(top - SIZE_W'(1));
    assign tgt_in   = {1'b0, target} < top;
    assign range_ne = top > {1'b0, range_start};

    always_comb
    begin
        lo_next      = target;
        hi_next      = target;
        span_ok_next = tgt_in;
        down_next    = 1'b0;
        unique case (cmd_in)
            CMD_FIRST:
            begin
                lo_next      = range_start;
                hi_next      = top_m1;
                span_ok_next = range_ne;
            end
            CMD_REVERSE:
            begin
                lo_next      = range_start;
                hi_next      = target;
                span_ok_next = tgt_in && (target >= range_start);
                down_next    = 1'b1;
            end
            CMD_LAST:
            begin
                lo_next      = range_start;
                hi_next      = top_m1;
                span_ok_next = range_ne;
                down_next    = 1'b1;
            end
            default:
            begin
                lo_next = target;
            end
        endcase
    end

    assign is_search = (cmd_reg == CMD_FIRST) || (cmd_reg == CMD_REVERSE)
                    || (cmd_reg == CMD_LAST);
    assign is_down   = (cmd_reg == CMD_REVERSE) || (cmd_reg == CMD_LAST);
    assign lo_word   = lo_reg[BIT_W +: WI];
    assign hi_word   = hi_reg[BIT_W +: WI];
    assign cur_word  = map_reg[word_reg];

    assign lo_mask = (word_reg == lo_word) ? ({MAP_W{1'b1}} << lo_reg[BIT_W-1:0])
                                           : {MAP_W{1'b1}};
    assign hi_mask = (word_reg == hi_word)
                   ? ({MAP_W{1'b1}} >> (BIT_W'(MAP_W - 1) - hi_reg[BIT_W-1:0]))
                   : {MAP_W{1'b1}};
    assign cand    = ~cur_word & lo_mask & hi_mask;
    assign hit_bit = is_down ? highest_set(cand) : lowest_set(cand);

    assign tgt_used = cur_word[target_reg[BIT_W-1:0]];

    always_comb
    begin
        single_ok = 1'b0;
        new_word  = cur_word;
        unique case (cmd_reg) inside
            CMD_QUERY:
            begin
                single_ok = span_ok_reg && tgt_used;
            end
            CMD_ALLOC:
            begin
                single_ok = span_ok_reg && !tgt_used;
                new_word[target_reg[BIT_W-1:0]] = 1'b1;
            end
            CMD_FREE:
            begin
                single_ok = span_ok_reg && tgt_used;
                new_word[target_reg[BIT_W-1:0]] = 1'b0;
            end
            CMD_FIRST, CMD_REVERSE, CMD_LAST:
            begin
                single_ok = 1'b0;
                new_word[hit_bit] = 1'b1;
            end
            default:
            begin
                single_ok = 1'b0;
            end
        endcase
    end

    assign sts.is_search = is_search;
    assign sts.span_ok   = span_ok_reg;
    assign sts.hit       = |cand;
    assign sts.last      = is_down ? (word_reg == lo_word) : (word_reg == hi_word);

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg     <= cmd_in;
            target_reg  <= target;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            span_ok_reg <= span_ok_next;
            word_reg    <= down_next ? hi_next[BIT_W +: WI] : lo_next[BIT_W +: WI];
        end
        else if (ctl.step && !ctl.finish)
        begin
            word_reg <= is_down ? (word_reg - WI'(1)) : (word_reg + WI'(1));
        end

        if (ctl.step && ctl.finish)
        begin
            if (is_search)
            begin
                ok_reg      <= span_ok_reg && sts.hit;
                granted_reg <= (span_ok_reg && sts.hit)
                             ? OFS_W'({word_reg, hit_bit}) : target_reg;
            end
            else
            begin
                ok_reg      <= single_ok;
                granted_reg <= target_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NWORDS; i++)
            begin
                map_reg[i] <= '0;
            end
        end
        else if (ctl.step && ctl.finish)
        begin
            if ((is_search && span_ok_reg && sts.hit) || (!is_search && single_ok
                && (cmd_reg == CMD_ALLOC || cmd_reg == CMD_FREE)))
            begin
                map_reg[word_reg] <= new_word;
            end
        end
    end

    assign ok      = ok_reg;
    assign granted = granted_reg;

endmodule

`default_nettype wire

[rtl/bitmap_offset_allocator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Bitmap offset allocator
// Tracks used offsets in a bitmap and hands out, checks and releases them.
// ----------------------------------------------------------------------------
// A command word (command, target) is taken at a rising edge with start high
// and busy low. Each command gives one result word (ok, granted), shown for
// exactly one cycle while done is high; the receiver cannot stall it.
// Query, designated alloc and free finish in one map access. Searches scan the
// map one 32-bit word per cycle through a priority encoder, from the range
// bottom up or from the upper bound down, and stop at the first free bit or
// the last word of the span. A new command may be started in the cycle in
// which done is high.
// The range registers are written through cfg_write, cfg_index and cfg_data;
// the user is to write them only while no command is in flight, and the
// block itself does not enforce this. Reset clears the whole map and sets
// the range to start 0 and size 1024.
// ----------------------------------------------------------------------------
module bitmap_offset_allocator
#(
    parameter int POOL_BITS = 1024
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [boa_pkg::CMD_W-1:0]     command,
    input  wire logic [boa_pkg::OFS_W-1:0]     target,
    output logic                               done,
    output logic                               ok,
    output logic [boa_pkg::OFS_W-1:0]          granted,
    input  wire logic                          cfg_write,
    input  wire logic                          cfg_index,
    input  wire logic [boa_pkg::SIZE_W-1:0]    cfg_data
);
    import boa_pkg::*;

    logic [OFS_W-1:0]  range_start_reg;
    logic [SIZE_W-1:0] range_size_reg;
    ctl_t              ctl;
    sts_t              sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_start_reg <= '0;
            range_size_reg  <= SIZE_W'(OFS_SPACE);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_START: range_start_reg <= cfg_data[OFS_W-1:0];
                CFG_SIZE:  range_size_reg  <= cfg_data;
                default:   range_size_reg  <= range_size_reg;
            endcase
        end
    end

    boa_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .sts   (sts),
        .ctl   (ctl)
    );

    boa_datapath
    #(
        .POOL_BITS (POOL_BITS)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .command     (command),
        .target      (target),
        .range_start (range_start_reg),
        .range_size  (range_size_reg),
        .ok          (ok),
        .granted     (granted)
    );

endmodule

`default_nettype wire
